@@ hw/rtl/uhst_pkg.sv @@
// Package for the hex serial transmitter: command codes, the classified
// operation that travels from the front to the back, and the hex digit map.
// Depends on nothing; the top, front, queue and back in hw/rtl use it.
package uhst_pkg;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_RAW      = 3'd1;
    localparam logic [2:0] CMD_HEX_NIB  = 3'd2;
    localparam logic [2:0] CMD_HEX_BYTE = 3'd3;
    localparam logic [2:0] CMD_HEX_WORD = 3'd4;
    localparam logic [2:0] CMD_HEX_LONG = 3'd5;

    // Configuration register indexes.
    localparam logic REG_BIT_PERIOD = 1'b0;

    localparam logic [15:0] BIT_PERIOD_RESET = 16'd104;

    // Bit positions within one character frame.
    localparam logic [3:0] POS_LAST_DATA = 4'd8;
    localparam logic [3:0] POS_STOP      = 4'd9;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_RAW  = 2'd1,
        OP_HEX  = 2'd2,
        OP_NONE = 2'd3
    } t_op_kind;

    // One classified item. For hex commands, last_digit is the index of the
    // most significant digit and value is already masked to its width.
    typedef struct packed {
        t_op_kind    kind;
        logic [2:0]  last_digit;
        logic [31:0] value;
    } t_op;

    // Push side of the queue, driven by the front.
    typedef struct packed {
        logic push;
        t_op  op;
    } t_push;

    // Lower-case ASCII for one hex digit.
    function automatic logic [7:0] hex_char(input logic [3:0] digit);
        logic [7:0] ch;
        if (digit >= 4'd10) begin
            ch = 8'h61 + {4'h0, digit} - 8'd10;
        end else begin
            ch = 8'h30 + {4'h0, digit};
        end
        return ch;
    endfunction

endpackage

@@ hw/rtl/uhst_in_if.sv @@
// Input channel of the hex serial transmitter: valid/ready plus command and
// value. Depends on nothing.
interface uhst_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] value;

    modport source (output valid, output command, output value, input ready);
    modport sink   (input valid, input command, input value, output ready);
endinterface

@@ hw/rtl/uhst_out_if.sv @@
// Result channel of the hex serial transmitter: valid/ready plus line level,
// busy flag and reject flag. Depends on nothing.
interface uhst_out_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic rejected;

    modport source (output valid, output line_level, output busy_res,
                    output rejected, input ready);
    modport sink   (input valid, input line_level, input busy_res,
                    input rejected, output ready);
endinterface

@@ hw/rtl/uart_hex_serial_transmitter_top.sv @@
// Top level of the 8N1 hex serial transmitter: APB register, front, queue
// and back. Depends on uhst_pkg, uhst_in_if, uhst_out_if and the submodules.
//
//   Channel   Direction  Contents
//   i_in      sink       command (3 bits), value (32 bits)
//   o_out     source     line_level, busy_res, rejected (1 bit each)
//   APB       slave      bit_period_ticks at byte address 0
//
// One item per clock cycle is sustained while results are taken: the back
// executes one queued operation each cycle unless its result register is
// full and not taken; each item passes the queue, then the result register.
// Reset is synchronous and active low; the line idles high after reset and
// the bit period returns to 104 ticks.
// The two-entry queue lets the input keep accepting while a result waits to
// be taken; when the result register and the queue are both full, input
// ready drops until the result is taken.
module uart_hex_serial_transmitter_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uhst_in_if.sink       i_in,
    uhst_out_if.source    o_out,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [2:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready
);

    logic [15:0] r_bit_period;
    logic        w_reg_sel;
    logic        w_cfg_write;

    uhst_pkg::t_push w_push;
    uhst_pkg::t_op   w_q_op;
    logic            w_q_not_full;
    logic            w_q_valid;
    logic            w_pop;

    // Configuration: the register index is the word address. Writes beyond
    // the register list are ignored and read back as zero.
    assign o_pready    = 1'b1;
    assign w_reg_sel   = (i_paddr[2] == uhst_pkg::REG_BIT_PERIOD);
    assign w_cfg_write = i_psel && i_penable && i_pwrite && o_pready;
    assign o_prdata    = w_reg_sel ? {16'h0, r_bit_period} : 32'h0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= uhst_pkg::BIT_PERIOD_RESET;
        end else if (w_cfg_write && w_reg_sel) begin
            r_bit_period <= i_pwdata[15:0];
        end
    end

    // Front: accept and classify.
    uhst_front u_front (
        .i_queue_ready (w_q_not_full),
        .i_valid       (i_in.valid),
        .i_command     (i_in.command),
        .i_value       (i_in.value),
        .o_ready       (i_in.ready),
        .o_push        (w_push)
    );

    // Queue decoupling the front from the back.
    uhst_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .o_not_full (w_q_not_full),
        .o_valid    (w_q_valid),
        .o_op       (w_q_op),
        .i_pop      (w_pop)
    );

    // Back: frame timing, digit sequencing and the result register.
    uhst_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_period (r_bit_period),
        .i_op_valid   (w_q_valid),
        .i_op         (w_q_op),
        .o_pop        (w_pop),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_line_level (o_out.line_level),
        .o_busy       (o_out.busy_res),
        .o_rejected   (o_out.rejected)
    );

endmodule

@@ hw/rtl/uhst_front.sv @@
// Front of the transmitter: accepts items and classifies each command into
// an operation with its last digit index and masked value. Uses uhst_pkg.
module uhst_front (
    input  logic                 i_queue_ready,
    input  logic                 i_valid,
    input  logic [2:0]           i_command,
    input  logic [31:0]          i_value,
    output logic                 o_ready,
    output uhst_pkg::t_push      o_push
);

    uhst_pkg::t_op w_op;

    always_comb begin
        w_op.kind       = uhst_pkg::OP_NONE;
        w_op.last_digit = 3'd0;
        w_op.value      = i_value;
        unique case (i_command)
            uhst_pkg::CMD_TICK: begin
                w_op.kind = uhst_pkg::OP_TICK;
            end
            uhst_pkg::CMD_RAW: begin
                w_op.kind  = uhst_pkg::OP_RAW;
                w_op.value = {24'h0, i_value[7:0]};
            end
            uhst_pkg::CMD_HEX_NIB: begin
                w_op.kind  = uhst_pkg::OP_HEX;
                w_op.value = {28'h0, i_value[3:0]};
            end
            uhst_pkg::CMD_HEX_BYTE: begin
                w_op.kind       = uhst_pkg::OP_HEX;
                w_op.last_digit = 3'd1;
                w_op.value      = {24'h0, i_value[7:0]};
            end
            uhst_pkg::CMD_HEX_WORD: begin
                w_op.kind       = uhst_pkg::OP_HEX;
                w_op.last_digit = 3'd3;
                w_op.value      = {16'h0, i_value[15:0]};
            end
            uhst_pkg::CMD_HEX_LONG: begin
                w_op.kind       = uhst_pkg::OP_HEX;
                w_op.last_digit = 3'd7;
            end
            default: begin
                w_op.kind = uhst_pkg::OP_NONE;
            end
        endcase
    end

    assign o_ready     = i_queue_ready;
    assign o_push.push = i_valid && i_queue_ready;
    assign o_push.op   = w_op;

endmodule

@@ hw/rtl/uhst_queue.sv @@
// Two-entry queue of classified operations between the front and the back.
// Uses uhst_pkg for the operation type and the depth.
module uhst_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  uhst_pkg::t_push  i_push,
    output logic             o_not_full,
    output logic             o_valid,
    output uhst_pkg::t_op    o_op,
    input  logic             i_pop
);

    localparam int PTR_W = $clog2(uhst_pkg::QUEUE_DEPTH);

    uhst_pkg::t_op      r_mem [uhst_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [PTR_W:0]     r_count, n_count;

    logic w_do_push, w_do_pop;

    assign o_not_full = (r_count != (PTR_W+1)'(uhst_pkg::QUEUE_DEPTH));
    assign o_valid    = (r_count != '0);
    assign o_op       = r_mem[r_rptr];
    assign w_do_push  = i_push.push && o_not_full;
    assign w_do_pop   = i_pop && o_valid;

    always_comb begin
        n_wptr  = r_wptr + PTR_W'(w_do_push);
        n_rptr  = r_rptr + PTR_W'(w_do_pop);
        n_count = r_count + (PTR_W+1)'(w_do_push) - (PTR_W+1)'(w_do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_push.op;
        end
    end

endmodule

@@ hw/rtl/uhst_back.sv @@
// Back (uses uhst_pkg): frame timing, hex digit sequencing and the result
// register. Executes one queued operation per cycle unless a result waits.
module uhst_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_bit_period,
    input  logic             i_op_valid,
    input  uhst_pkg::t_op    i_op,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic             o_line_level,
    output logic             o_busy,
    output logic             o_rejected
);

    logic [31:0] r_pending, n_pending;
    logic [3:0]  r_digits, n_digits;
    logic        r_raw, n_raw;
    logic [7:0]  r_char, n_char;
    logic [3:0]  r_pos, n_pos;
    logic [15:0] r_ticks, n_ticks;
    logic        r_line, n_line;
    logic        r_active, n_active;
    logic        r_out_valid, n_out_valid;
    logic        r_rejected, n_rejected;

    logic [15:0] w_period;
    logic [16:0] w_tick_next;
    logic [3:0]  w_pos_next;
    logic [2:0]  w_next_idx;
    logic [2:0]  w_data_idx;

    assign o_pop        = i_op_valid && (!r_out_valid || i_ready);
    assign o_valid      = r_out_valid;
    assign o_line_level = r_line;
    assign o_busy       = r_active;
    assign o_rejected   = r_rejected;

    // A period of zero behaves as one tick per bit.
    assign w_period    = (i_bit_period == 16'd0) ? 16'd1 : i_bit_period;
    assign w_tick_next = {1'b0, r_ticks} + 17'd1;
    assign w_pos_next  = r_pos + 4'd1;
    assign w_next_idx  = r_digits[2:0] - 3'd1;
    assign w_data_idx  = r_pos[2:0];

    always_comb begin
        n_pending   = r_pending;
        n_digits    = r_digits;
        n_raw       = r_raw;
        n_char      = r_char;
        n_pos       = r_pos;
        n_ticks     = r_ticks;
        n_line      = r_line;
        n_active    = r_active;
        n_rejected  = r_rejected;
        n_out_valid = r_out_valid && !i_ready;

        if (o_pop) begin
            n_out_valid = 1'b1;
            n_rejected  = 1'b0;
            case (i_op.kind)
                uhst_pkg::OP_TICK: begin
                    if (r_active) begin
                        if (w_tick_next < {1'b0, w_period}) begin
                            n_ticks = w_tick_next[15:0];
                        end else begin
                            n_ticks = 16'd0;
                            n_pos   = w_pos_next;
                            if (w_pos_next <= uhst_pkg::POS_LAST_DATA) begin
                                // Data bit k sits at position k+1.
                                n_line = r_char[w_data_idx];
                            end else if (w_pos_next == uhst_pkg::POS_STOP) begin
                                n_line = 1'b1;
                            end else if (r_digits != 4'd0 && !r_raw) begin
                                n_digits = r_digits - 4'd1;
                                n_char   = uhst_pkg::hex_char(
                                    r_pending[{w_next_idx, 2'b00} +: 4]);
                                n_pos    = 4'd0;
                                n_line   = 1'b0;
                            end else begin
                                n_pos    = 4'd0;
                                n_digits = 4'd0;
                                n_line   = 1'b1;
                                n_active = 1'b0;
                            end
                        end
                    end
                end
                uhst_pkg::OP_RAW, uhst_pkg::OP_HEX: begin
                    if (r_active) begin
                        n_rejected = 1'b1;
                    end else begin
                        n_pos    = 4'd0;
                        n_ticks  = 16'd0;
                        n_line   = 1'b0;
                        n_active = 1'b1;
                        if (i_op.kind == uhst_pkg::OP_RAW) begin
                            n_raw    = 1'b1;
                            n_digits = 4'd0;
                            n_char   = i_op.value[7:0];
                        end else begin
                            n_raw     = 1'b0;
                            n_pending = i_op.value;
                            n_digits  = {1'b0, i_op.last_digit};
                            n_char    = uhst_pkg::hex_char(
                                i_op.value[{i_op.last_digit, 2'b00} +: 4]);
                        end
                    end
                end
                default: begin
                    // Unused codes only post a result with reject clear.
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 32'd0;
            r_digits    <= 4'd0;
            r_raw       <= 1'b0;
            r_char      <= 8'd0;
            r_pos       <= 4'd0;
            r_ticks     <= 16'd0;
            r_line      <= 1'b1;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
            r_rejected  <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_digits    <= n_digits;
            r_raw       <= n_raw;
            r_char      <= n_char;
            r_pos       <= n_pos;
            r_ticks     <= n_ticks;
            r_line      <= n_line;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
            r_rejected  <= n_rejected;
        end
    end

endmodule
